[rtl/igfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igfr_pkg
// Shared types and constants of the idle-gap frame receiver.
// ----------------------------------------------------------------------------
package igfr_pkg;

   localparam int FRAME_CAPACITY   = 64;
   localparam int ADDR_W           = $clog2(FRAME_CAPACITY);
   localparam int COUNT_W          = 7;
   localparam int INDEX_W          = 6;
   localparam int BYTE_W           = 8;

   localparam logic [COUNT_W-1:0] CAPACITY_COUNT = COUNT_W'(FRAME_CAPACITY);
   localparam logic [BYTE_W-1:0]  IDLE_TICKS_RESET = 8'd3;

   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SEND
   } igfr_state_type;

   typedef struct packed {
      logic               load;
      logic [INDEX_W-1:0] index;
      logic [COUNT_W-1:0] length;
      logic               last;
      logic [BYTE_W-1:0]  number;
      logic               overflowed;
   } igfr_rsp_load_type;

endpackage

[rtl/igfr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igfr_if
// Request and response channels of the idle-gap frame receiver.
// ----------------------------------------------------------------------------
interface igfr_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface igfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic [5:0] byte_index;
   logic [6:0] frame_length;
   logic       last;
   logic [7:0] frame_number;
   logic       overflowed;

   modport source (output valid, output frame_byte, output byte_index,
                   output frame_length, output last, output frame_number,
                   output overflowed, input ready);
   modport sink   (input valid, input frame_byte, input byte_index,
                   input frame_length, input last, input frame_number,
                   input overflowed, output ready);
endinterface

[rtl/igfr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module igfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/igfr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// igfr_ctrl
// Frame state, idle counter and readout sequencer around one index unit.
// ----------------------------------------------------------------------------
module igfr_ctrl
   import igfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   input  logic [BYTE_W-1:0]      req_byte,
   output logic                   req_ready,
   input  logic [BYTE_W-1:0]      idle_ticks,
   input  logic                   rsp_taken,
   output logic                   ram_wr_en,
   output logic [ADDR_W-1:0]      ram_wr_addr,
   output logic [BYTE_W-1:0]      ram_wr_data,
   output logic                   ram_rd_en,
   output logic [ADDR_W-1:0]      ram_rd_addr,
   output igfr_rsp_load_type      rsp_load
);

   igfr_state_type     state_ff, state_in;
   logic [BYTE_W-1:0]  idle_count_ff, idle_count_in;
   logic               frame_open_ff, frame_open_in;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0]  frames_done_ff, frames_done_in;
   logic               overflow_ff, overflow_in;
   logic [COUNT_W-1:0] index_ff, index_in;

   // shared index unit: advance and last-byte compare
   logic [COUNT_W-1:0] index_next;
   logic               index_last;

   assign index_next = index_ff + 1'b1;
   assign index_last = (index_next == byte_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idle_count_ff  <= '0;
         frame_open_ff  <= 1'b0;
         byte_count_ff  <= '0;
         frames_done_ff <= '0;
         overflow_ff    <= 1'b0;
         index_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         idle_count_ff  <= idle_count_in;
         frame_open_ff  <= frame_open_in;
         byte_count_ff  <= byte_count_in;
         frames_done_ff <= frames_done_in;
         overflow_ff    <= overflow_in;
         index_ff       <= index_in;
      end
   end

   always_comb begin
      logic [COUNT_W-1:0] count_base;
      logic               ov_base;

      state_in       = state_ff;
      idle_count_in  = idle_count_ff;
      frame_open_in  = frame_open_ff;
      byte_count_in  = byte_count_ff;
      frames_done_in = frames_done_ff;
      overflow_in    = overflow_ff;
      index_in       = index_ff;

      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = byte_count_ff[ADDR_W-1:0];
      ram_wr_data = req_byte;
      ram_rd_en   = 1'b0;
      ram_rd_addr = index_ff[ADDR_W-1:0];

      rsp_load.load       = 1'b0;
      rsp_load.index      = index_ff[INDEX_W-1:0];
      rsp_load.length     = byte_count_ff;
      rsp_load.last       = index_last;
      rsp_load.number     = frames_done_ff;
      rsp_load.overflowed = overflow_ff;

      // a byte after the idle gap restarts the frame
      count_base = (idle_count_ff == '0) ? '0 : byte_count_ff;
      ov_base    = (idle_count_ff == '0) ? 1'b0 : overflow_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode == MODE_BYTE) begin
                  frame_open_in = 1'b1;
                  idle_count_in = idle_ticks;
                  ram_wr_addr   = count_base[ADDR_W-1:0];
                  if (count_base < CAPACITY_COUNT) begin
                     ram_wr_en     = 1'b1;
                     byte_count_in = count_base + 1'b1;
                     overflow_in   = ov_base;
                  end else begin
                     byte_count_in = count_base;
                     overflow_in   = 1'b1;
                  end
               end else if (idle_count_ff != '0) begin
                  idle_count_in = idle_count_ff - 1'b1;
               end else if (frame_open_ff) begin
                  frame_open_in  = 1'b0;
                  frames_done_in = frames_done_ff + 1'b1;
                  index_in       = '0;
                  state_in       = ST_READ;
               end
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            rsp_load.load = 1'b1;
            state_in      = ST_SEND;
         end
         ST_SEND: begin
            // hold until the response is taken
            if (rsp_taken) begin
               if (index_last) begin
                  state_in = ST_IDLE;
               end else begin
                  index_in = index_next;
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/idle_gap_frame_receiver_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_gap_frame_receiver_core
// Groups received bytes into frames closed by an idle gap of timer ticks.
// ----------------------------------------------------------------------------
//  channel  direction  carries
//  req_ch   in         mode, rx_byte (byte or timer tick)
//  rsp_ch   out        frame_byte, byte_index, frame_length, last,
//                      frame_number, overflowed
//  csr_*    in         idle_ticks write (wr_en, wr_data)
//
//  A byte or a tick that closes no frame is accepted without holding off
//  requests. Once a closing tick of an N-byte frame is accepted, requests
//  are held off while the readout sequencer runs, for each byte, a RAM
//  read, an output load and a handshake; a stalled response holds them
//  off longer.
//  Reset is synchronous; the byte store needs no clearing pass.
// ----------------------------------------------------------------------------
module idle_gap_frame_receiver_core
   import igfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   igfr_req_if.sink          req_ch,
   igfr_rsp_if.source        rsp_ch,
   input  logic              csr_wr_en,
   input  logic [BYTE_W-1:0] csr_wr_data
);

   logic [BYTE_W-1:0]  idle_ticks_ff;
   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  frame_byte_ff;
   logic [INDEX_W-1:0] byte_index_ff;
   logic [COUNT_W-1:0] frame_length_ff;
   logic               last_ff;
   logic [BYTE_W-1:0]  frame_number_ff;
   logic               overflowed_ff;

   logic               rsp_taken;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [BYTE_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [BYTE_W-1:0]  ram_rd_data;
   igfr_rsp_load_type  rsp_load;

   assign rsp_taken = rsp_valid_ff & rsp_ch.ready;

   igfr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_mode    (req_ch.mode),
      .req_byte    (req_ch.rx_byte),
      .req_ready   (req_ch.ready),
      .idle_ticks  (idle_ticks_ff),
      .rsp_taken   (rsp_taken),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .rsp_load    (rsp_load)
   );

   igfr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ticks_ff <= IDLE_TICKS_RESET;
      end else if (csr_wr_en) begin
         idle_ticks_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_taken) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // capture one response from the store read
   always_ff @(posedge clock) begin
      if (rsp_load.load) begin
         frame_byte_ff   <= ram_rd_data;
         byte_index_ff   <= rsp_load.index;
         frame_length_ff <= rsp_load.length;
         last_ff         <= rsp_load.last;
         frame_number_ff <= rsp_load.number;
         overflowed_ff   <= rsp_load.overflowed;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frame_byte   = frame_byte_ff;
   assign rsp_ch.byte_index   = byte_index_ff;
   assign rsp_ch.frame_length = frame_length_ff;
   assign rsp_ch.last         = last_ff;
   assign rsp_ch.frame_number = frame_number_ff;
   assign rsp_ch.overflowed   = overflowed_ff;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the idle-gap frame receiver core. A driver sends
// bytes and timer ticks with random gaps. A monitor takes frame bytes with
// random stalls and compares each one field by field against a frame
// tracker that runs on every accepted request. Phases switch idle_ticks
// between 0, 1, 255, 2 and random values.
// ----------------------------------------------------------------------------
module testbench;
   import igfr_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SIDE_REQ       = 0;
   localparam int SIDE_RSP       = 1;

   typedef struct packed {
      logic              mode;
      logic [BYTE_W-1:0] rx_byte;
   } request_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data;
      logic [INDEX_W-1:0] index;
      logic [COUNT_W-1:0] length;
      logic               last;
      logic [BYTE_W-1:0]  number;
      logic               overflowed;
   } frame_byte_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [BYTE_W-1:0] csr_wr_data;

   igfr_req_if req_ch ();
   igfr_rsp_if rsp_ch ();

   idle_gap_frame_receiver_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   request_type    request_backlog[$];
   frame_byte_type owed_bytes[$];

   // frame tracker state
   logic [BYTE_W-1:0]  ticks_setting;
   logic [BYTE_W-1:0]  gap_count;
   logic               frame_active;
   logic [BYTE_W-1:0]  frame_bytes[FRAME_CAPACITY];
   logic [COUNT_W-1:0] stored_count;
   logic [BYTE_W-1:0]  frames_closed;
   logic               bytes_dropped;

   int error_count      = 0;
   int requests_queued  = 0;
   int requests_taken   = 0;
   int bytes_checked    = 0;
   int frames_total     = 0;
   int overflow_frames  = 0;
   int settings_written = 0;
   int run_left[2]      = '{0, 0};
   bit calm_run[2]      = '{1'b0, 1'b0};

   // Per-item wait, with stretches where a side does not idle at all.
   function int draw_wait(input int side);
      if (run_left[side] == 0) begin
         run_left[side] = $urandom_range(8, 40);
         calm_run[side] = ($urandom_range(0, 2) == 0);
      end
      run_left[side] = run_left[side] - 1;
      return calm_run[side] ? 0 : $urandom_range(0, 10);
   endfunction

   task automatic track_frame(input request_type r);
      frame_byte_type fb;
      int             i;
      if (r.mode == MODE_BYTE) begin
         // a byte after a full gap restarts the frame, dropping the old one
         if (gap_count == '0) begin
            stored_count  = '0;
            bytes_dropped = 1'b0;
            frame_active  = 1'b1;
         end
         if (frame_active) begin
            gap_count = ticks_setting;
            if (stored_count < CAPACITY_COUNT) begin
               frame_bytes[stored_count[INDEX_W-1:0]] = r.rx_byte;
               stored_count = stored_count + 1'b1;
            end else begin
               bytes_dropped = 1'b1;
            end
         end
      end else if (gap_count != '0) begin
         gap_count = gap_count - 1'b1;
      end else if (frame_active) begin
         frame_active  = 1'b0;
         frames_closed = frames_closed + 1'b1;
         frames_total++;
         if (bytes_dropped) overflow_frames++;
         for (i = 0; i < int'(stored_count); i++) begin
            fb.data       = frame_bytes[i];
            fb.index      = INDEX_W'(i);
            fb.length     = stored_count;
            fb.last       = (i + 1 == int'(stored_count));
            fb.number     = frames_closed;
            fb.overflowed = bytes_dropped;
            owed_bytes.push_back(fb);
         end
      end
   endtask

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t: %s mismatch, got %0d, want %0d", $realtime, field, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------- driver
   int req_wait = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            track_frame(request_type'{req_ch.mode, req_ch.rx_byte});
            requests_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_wait > 0) begin
               req_wait = req_wait - 1;
               req_ch.valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               req_ch.valid   <= 1'b1;
               req_ch.mode    <= request_backlog[0].mode;
               req_ch.rx_byte <= request_backlog[0].rx_byte;
               void'(request_backlog.pop_front());
               req_wait = draw_wait(SIDE_REQ);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------- monitor
   int rsp_wait = 0;

   always @(posedge clock) begin
      frame_byte_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            bytes_checked++;
            if (owed_bytes.size() == 0) begin
               $display("%0t: frame byte %0d with none outstanding", $realtime,
                        rsp_ch.frame_byte);
               error_count++;
            end else begin
               want = owed_bytes.pop_front();
               if (rsp_ch.frame_byte !== want.data)
                  report_mismatch("frame_byte", rsp_ch.frame_byte, want.data);
               if (rsp_ch.byte_index !== want.index)
                  report_mismatch("byte_index", rsp_ch.byte_index, want.index);
               if (rsp_ch.frame_length !== want.length)
                  report_mismatch("frame_length", rsp_ch.frame_length, want.length);
               if (rsp_ch.last !== want.last)
                  report_mismatch("last", rsp_ch.last, want.last);
               if (rsp_ch.frame_number !== want.number)
                  report_mismatch("frame_number", rsp_ch.frame_number, want.number);
               if (rsp_ch.overflowed !== want.overflowed)
                  report_mismatch("overflowed", rsp_ch.overflowed, want.overflowed);
            end
            rsp_wait = draw_wait(SIDE_RSP);
         end else if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
         end
         rsp_ch.ready <= (rsp_wait == 0);
      end
   end

   // -------------------------------------------------------------- watchdog
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_wr_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d frame bytes outstanding",
                     WATCHDOG_LIMIT, owed_bytes.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------- stimulus
   task automatic queue_request(input logic mode, input logic [BYTE_W-1:0] value);
      request_backlog.push_back(request_type'{mode, value});
      requests_queued++;
   endtask

   task automatic queue_ticks(input int n);
      repeat (n) queue_request(MODE_TICK, BYTE_W'($urandom));
   endtask

   // Frame of len bytes; idle ticks between bytes stay short of the gap.
   task automatic queue_frame(input int len, input int setting);
      int i;
      for (i = 0; i < len; i++) begin
         queue_request(MODE_BYTE, BYTE_W'($urandom));
         if (setting > 0 && i < len - 1 && $urandom_range(0, 3) == 0)
            queue_ticks($urandom_range(0, (setting > 24) ? 3 : setting - 1));
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_ch.valid || owed_bytes.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_idle_ticks(input logic [BYTE_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      ticks_setting = value;
      settings_written++;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(input int setting);
      int seq_count;
      int s;
      int pick;
      bit left_open;
      write_idle_ticks(BYTE_W'(setting));
      left_open = 1'b0;
      seq_count = (setting >= 100) ? 1 : $urandom_range(2, 4);
      for (s = 0; s < seq_count; s++) begin
         pick = (setting >= 100) ? 0 : $urandom_range(0, 19);
         if (pick < 14) begin
            queue_frame($urandom_range(1, 12), setting);
            // close the frame, sometimes with spare ticks on a closed frame
            queue_ticks(setting + 1 + (($urandom_range(0, 3) == 0) ?
                                       $urandom_range(1, 3) : 0));
            left_open = 1'b0;
         end else if (pick < 17) begin
            queue_frame($urandom_range(1, 8), setting);
            queue_ticks($urandom_range(0, setting));
            left_open = 1'b1;
         end else begin
            repeat ($urandom_range(1, 6))
               queue_request(logic'($urandom_range(0, 1)), BYTE_W'($urandom));
            left_open = 1'b1;
         end
      end
      // leave nothing open for the next setting
      if (left_open) queue_ticks(setting + 1);
      wait_drained();
   endtask

   initial begin
      int phase;
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_ch.valid     = 1'b0;
      req_ch.mode      = MODE_TICK;
      req_ch.rx_byte   = '0;
      rsp_ch.ready     = 1'b0;
      ticks_setting    = IDLE_TICKS_RESET;
      gap_count        = '0;
      frame_active     = 1'b0;
      stored_count     = '0;
      frames_closed    = '0;
      bytes_dropped    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, at the reset value of idle_ticks (3)
      queue_request(MODE_BYTE, 8'h00);
      queue_request(MODE_BYTE, 8'hFF);
      queue_ticks(4);
      // tick with no frame open
      queue_ticks(1);
      // byte in the middle of the gap reloads the idle counter
      queue_request(MODE_BYTE, 8'hA5);
      queue_ticks(1);
      queue_request(MODE_BYTE, 8'h5A);
      queue_ticks(4);
      // gap runs out without a closing tick: next byte drops the old frame
      queue_request(MODE_BYTE, 8'h11);
      queue_ticks(3);
      queue_request(MODE_BYTE, 8'h22);
      queue_ticks(4);
      // over-long frame: bytes past capacity are dropped and flagged
      repeat (FRAME_CAPACITY + 2) queue_request(MODE_BYTE, BYTE_W'($urandom));
      queue_ticks(4);
      wait_drained();

      phase = 0;
      while (phase < 6) begin
         case (phase)
            0:       run_phase(0);
            1:       run_phase(1);
            2:       run_phase(255);
            3:       run_phase(2);
            4:       run_phase($urandom_range(1, 8));
            default: run_phase($urandom_range(3, 12));
         endcase
         phase++;
      end
      wait_drained();

      $display("Sent %0d requests over %0d idle_ticks settings, %0d frames closed",
               requests_taken, settings_written, frames_total);
      $display("Checked %0d frame bytes, %0d frames had dropped bytes",
               bytes_checked, overflow_frames);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[idle_gap_frame_receiver_core.f]
rtl/igfr_pkg.sv
rtl/igfr_if.sv
rtl/igfr_ram.sv
rtl/igfr_ctrl.sv
rtl/idle_gap_frame_receiver_core.sv
dv/testbench.sv
